@@ hw/rtl/spi_master_byte_engine_macros.svh @@
// ----------------------------------------------------------------------------
// SPI master byte engine assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_BYTE_ENGINE_MACROS_SVH
`define SPI_MASTER_BYTE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine package
// Beat payload types, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int DATA_BITS = 8;
    localparam int COUNT_W   = 4;
    localparam int PRESC_W   = 7;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_SELECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE = 3'd4;

    localparam logic [2:0] DIV_SELECT_MAX   = 3'd6;
    localparam logic [2:0] DIV_SELECT_RESET = 3'd1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [DATA_BITS-1:0] write_data;
        logic                 miso;
    } t_req;

    typedef struct packed {
        logic                 sck;
        logic                 mosi;
        logic [DATA_BITS-1:0] read_data;
        logic                 transfer_done;
        logic                 write_collision;
        logic                 busy_res;
        logic                 irq;
    } t_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/sme_stream_if.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine stream channel
// Valid/ready channel carrying one payload beat per accepted handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sme_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/spi_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine
// Tick-driven SPI master for modes 0 to 3 with one status beat per tick.
// ----------------------------------------------------------------------------
// Usage: every beat on i_req is one system tick of the serial engine. It may
// carry a data register write (which starts an 8-bit exchange when idle) or a
// read (which clears the done and collision flags). For every accepted
// request beat exactly one status beat leaves on o_rsp, showing sck, mosi,
// the received byte, the flags, busy and irq as they stand after that tick.
// Configuration goes through the plain write port and is meant to change
// only while no beat is in flight.
// The next state and the status beat are computed in a single pass of logic
// between the state registers and the output register.
// Throughput is one beat per cycle while the receiver does not stall; the
// engine has no multi-cycle unit.
// A two-entry output stage (output register plus skid register) lets a
// request be taken while a status beat still waits. When the receiver
// stalls, the skid register fills and i_req.ready drops until it drains.
// Synchronous reset clears the engine to idle, the flags to zero, sck to the
// reset polarity (low) and the divider select to one; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_master_byte_engine_macros.svh"

module spi_master_byte_engine (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [sme_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [sme_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sme_stream_if.sink                    i_req,
    sme_stream_if.source                  o_rsp
);
    import sme_pkg::*;

    // Configuration registers.
    logic       r_lsb_first;
    logic       r_clock_pol;
    logic       r_clock_pha;
    logic [2:0] r_div_select;
    logic       r_irq_enable;

    // Engine state.
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [COUNT_W-1:0]   r_bit_count, n_bit_count;
    logic [PRESC_W-1:0]   r_prescale, n_prescale;
    logic                 r_clock_level, n_clock_level;
    logic                 r_active, n_active;
    logic [DATA_BITS-1:0] r_rx_buffer, n_rx_buffer;
    logic                 r_done, n_done;
    logic                 r_collision, n_collision;
    logic                 r_mosi, n_mosi;

    // Output stage.
    t_req req;
    t_rsp n_rsp;
    t_rsp r_out;
    t_rsp r_skid;
    logic r_out_v;
    logic r_skid_v;

    logic in_fire;
    logic out_fire;

    assign req      = i_req.data;
    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = r_out_v && o_rsp.ready;

    assign i_req.ready = !r_skid_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_out;

    // One tick of the engine: the request is handled first, then the
    // prescaler advances and may produce a serial clock edge.
    always_comb begin
        logic       started;
        logic       leading;
        logic       sample_now;
        logic [2:0] sel;
        logic [PRESC_W-1:0] half;

        n_shift       = r_shift;
        n_bit_count   = r_bit_count;
        n_prescale    = r_prescale;
        n_clock_level = r_clock_level;
        n_active      = r_active;
        n_rx_buffer   = r_rx_buffer;
        n_done        = r_done;
        n_collision   = r_collision;
        n_mosi        = r_mosi;
        started       = 1'b0;
        leading       = 1'b0;
        sample_now    = 1'b0;
        sel           = (r_div_select > DIV_SELECT_MAX) ? DIV_SELECT_MAX : r_div_select;
        half          = PRESC_W'(1) << sel;

        case (req.req_type)
            REQ_WRITE: begin
                if (r_active) begin
                    n_collision = 1'b1;
                end else begin
                    n_shift       = req.write_data;
                    n_bit_count   = '0;
                    n_prescale    = '0;
                    n_clock_level = r_clock_pol;
                    n_active      = 1'b1;
                    started       = 1'b1;
                    // In phase zero the first bit must be on the line before
                    // the leading edge.
                    if (!r_clock_pha) begin
                        n_mosi = r_lsb_first ? req.write_data[0]
                                             : req.write_data[DATA_BITS-1];
                    end
                end
            end
            REQ_READ: begin
                n_done      = 1'b0;
                n_collision = 1'b0;
            end
            default: begin
            end
        endcase

        if (n_active && !started) begin
            n_prescale = n_prescale + PRESC_W'(1);
            if (n_prescale >= half) begin
                n_prescale    = '0;
                leading       = (n_clock_level == r_clock_pol);
                sample_now    = r_clock_pha ? !leading : leading;
                n_clock_level = !n_clock_level;
                if (sample_now) begin
                    n_shift = r_lsb_first ? {req.miso, n_shift[DATA_BITS-1:1]}
                                          : {n_shift[DATA_BITS-2:0], req.miso};
                    if (n_bit_count < COUNT_W'(DATA_BITS)) begin
                        n_bit_count = n_bit_count + COUNT_W'(1);
                    end
                end else if (n_bit_count < COUNT_W'(DATA_BITS)) begin
                    n_mosi = r_lsb_first ? n_shift[0] : n_shift[DATA_BITS-1];
                end
                // The trailing edge after the last sample ends the byte.
                if (!leading && (n_bit_count >= COUNT_W'(DATA_BITS))) begin
                    n_rx_buffer = n_shift;
                    n_done      = 1'b1;
                    n_active    = 1'b0;
                    n_bit_count = '0;
                    n_prescale  = '0;
                end
            end
        end

        if (!n_active) begin
            n_clock_level = r_clock_pol;
        end

        n_rsp.sck             = n_clock_level;
        n_rsp.mosi            = n_mosi;
        n_rsp.read_data       = n_rx_buffer;
        n_rsp.transfer_done   = n_done;
        n_rsp.write_collision = n_collision;
        n_rsp.busy_res        = n_active;
        n_rsp.irq             = n_done && r_irq_enable;
    end

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_first  <= 1'b0;
            r_clock_pol  <= 1'b0;
            r_clock_pha  <= 1'b0;
            r_div_select <= DIV_SELECT_RESET;
            r_irq_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LSB_FIRST:  r_lsb_first  <= i_cfg_data[0];
                CFG_CLOCK_POL:  r_clock_pol  <= i_cfg_data[0];
                CFG_CLOCK_PHA:  r_clock_pha  <= i_cfg_data[0];
                CFG_DIV_SELECT: r_div_select <= i_cfg_data;
                CFG_IRQ_ENABLE: r_irq_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Engine state advances only on an accepted request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift       <= '0;
            r_bit_count   <= '0;
            r_prescale    <= '0;
            r_clock_level <= 1'b0;
            r_active      <= 1'b0;
            r_rx_buffer   <= '0;
            r_done        <= 1'b0;
            r_collision   <= 1'b0;
            r_mosi        <= 1'b0;
        end else if (in_fire) begin
            r_shift       <= n_shift;
            r_bit_count   <= n_bit_count;
            r_prescale    <= n_prescale;
            r_clock_level <= n_clock_level;
            r_active      <= n_active;
            r_rx_buffer   <= n_rx_buffer;
            r_done        <= n_done;
            r_collision   <= n_collision;
            r_mosi        <= n_mosi;
        end
    end

    // Output register and skid register valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_skid_v <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_v && !out_fire) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    // Payload side of the output stage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_v && !out_fire) begin
                r_skid <= n_rsp;
            end else begin
                r_out <= n_rsp;
            end
        end
    end

    `SME_ASSERT_NOW(a_skid_implies_out, r_skid_v, r_out_v, "skid beat held with empty output register")
    `SME_ASSERT_NEXT(a_stall_fills_skid, in_fire && r_out_v && !o_rsp.ready, r_skid_v, "beat accepted under stall was not parked")
    `SME_ASSERT_NOW(a_idle_count_clear, !r_active, r_bit_count == '0, "bit count left nonzero while idle")
    `SME_ASSERT_NOW(a_irq_needs_done, r_out_v && r_out.irq, r_out.transfer_done, "interrupt without done flag")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master byte engine regression bench
// Feeds tick beats (writes, reads, plain and unused ticks) through the request
// channel under bursty sending and a stalling receiver. A cycle model predicts
// every status beat, and each received beat is compared field by field.
// ----------------------------------------------------------------------------

module testbench;
    import sme_pkg::*;

    // Request code that the engine treats as a plain tick.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycle model of the engine plus the queue of status beats it predicts.
    class spi_status_scoreboard;
        bit                 lsb_first, cpol, cpha, irq_en;
        bit [2:0]           div_sel;
        bit [DATA_BITS-1:0] shift_q, rx_byte;
        bit [COUNT_W-1:0]   bits_done;
        bit [PRESC_W-1:0]   presc;
        bit                 sck_lvl, busy, done_f, coll_f, mosi_lvl;
        t_rsp               status_q[$];
        int                 errors;

        function new();
            lsb_first = 1'b0;
            cpol      = 1'b0;
            cpha      = 1'b0;
            irq_en    = 1'b0;
            div_sel   = DIV_SELECT_RESET;
            shift_q   = '0;
            rx_byte   = '0;
            bits_done = '0;
            presc     = '0;
            sck_lvl   = 1'b0;
            busy      = 1'b0;
            done_f    = 1'b0;
            coll_f    = 1'b0;
            mosi_lvl  = 1'b0;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LSB_FIRST:  lsb_first = val[0];
                CFG_CLOCK_POL:  cpol      = val[0];
                CFG_CLOCK_PHA:  cpha      = val[0];
                CFG_DIV_SELECT: div_sel   = val;
                CFG_IRQ_ENABLE: irq_en    = val[0];
                default: ;
            endcase
        endfunction

        function bit tx_bit();
            return lsb_first ? shift_q[0] : shift_q[DATA_BITS-1];
        endfunction

        function void serial_edge(bit miso_v);
            bit leading;
            bit sample_now;
            leading    = (sck_lvl == cpol);
            sample_now = cpha ? !leading : leading;
            sck_lvl    = ~sck_lvl;
            if (sample_now) begin
                if (lsb_first)
                    shift_q = {miso_v, shift_q[DATA_BITS-1:1]};
                else
                    shift_q = {shift_q[DATA_BITS-2:0], miso_v};
                if (bits_done < COUNT_W'(DATA_BITS))
                    bits_done++;
            end else if (bits_done < COUNT_W'(DATA_BITS)) begin
                mosi_lvl = tx_bit();
            end
            // The byte completes on the trailing edge after the last sample.
            if (!leading && bits_done >= COUNT_W'(DATA_BITS)) begin
                rx_byte   = shift_q;
                done_f    = 1'b1;
                busy      = 1'b0;
                bits_done = '0;
                presc     = '0;
            end
        endfunction

        function void note_request(t_req r);
            bit       started;
            bit [2:0] eff;
            t_rsp     exp_beat;
            started = 1'b0;
            if (r.req_type == REQ_WRITE) begin
                if (busy) begin
                    coll_f = 1'b1;
                end else begin
                    shift_q   = r.write_data;
                    bits_done = '0;
                    presc     = '0;
                    sck_lvl   = cpol;
                    busy      = 1'b1;
                    started   = 1'b1;
                    if (!cpha)
                        mosi_lvl = tx_bit();
                end
            end else if (r.req_type == REQ_READ) begin
                done_f = 1'b0;
                coll_f = 1'b0;
            end
            // No edge in the tick that starts a transfer.
            if (busy && !started) begin
                eff   = (div_sel > DIV_SELECT_MAX) ? DIV_SELECT_MAX : div_sel;
                presc = presc + 1'b1;
                if (int'(presc) >= (1 << eff)) begin
                    presc = '0;
                    serial_edge(r.miso);
                end
            end
            if (!busy)
                sck_lvl = cpol;
            exp_beat.sck             = sck_lvl;
            exp_beat.mosi            = mosi_lvl;
            exp_beat.read_data       = rx_byte;
            exp_beat.transfer_done   = done_f;
            exp_beat.write_collision = coll_f;
            exp_beat.busy_res        = busy;
            exp_beat.irq             = done_f & irq_en;
            status_q.push_back(exp_beat);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_status(t_rsp got);
            t_rsp exp_beat;
            if (status_q.size() == 0) begin
                $error("status beat arrived with no request waiting for it");
                errors++;
                return;
            end
            exp_beat = status_q.pop_front();
            compare_field("sck", 8'(exp_beat.sck), 8'(got.sck));
            compare_field("mosi", 8'(exp_beat.mosi), 8'(got.mosi));
            compare_field("read_data", exp_beat.read_data, got.read_data);
            compare_field("transfer_done", 8'(exp_beat.transfer_done),
                          8'(got.transfer_done));
            compare_field("write_collision", 8'(exp_beat.write_collision),
                          8'(got.write_collision));
            compare_field("busy_res", 8'(exp_beat.busy_res), 8'(got.busy_res));
            compare_field("irq", 8'(exp_beat.irq), 8'(got.irq));
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sme_stream_if #(.T_PAYLOAD(t_req)) req_if ();
    sme_stream_if #(.T_PAYLOAD(t_rsp)) rsp_if ();

    spi_status_scoreboard sb;

    int       burst_left;
    int       stall_left;
    int       ticks_left;
    bit       read_owed;
    bit [2:0] cur_div;

    spi_master_byte_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: quiet windows with ready held high, otherwise random stalls.
    initial begin
        int cyc_count;
        cyc_count     = 0;
        stall_left    = 0;
        rsp_if.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc_count++;
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if ((cyc_count / 300) % 3 != 0 && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // Both channels are sampled at the edge, before any driven update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_status(rsp_if.data);
        end
    end

    initial begin
        #10_000_000;
        $display("spi_master_byte_engine regression: fail");
        $finish;
    end

    // Sender works in bursts; a new burst may start after a random gap.
    task automatic send_beat(input t_req beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
    endtask

    // Stops sending and waits for every predicted status beat.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
        if (idx == CFG_DIV_SELECT)
            cur_div = val;
    endtask

    task automatic apply_settings(input bit lsb, input bit pol, input bit pha,
                                  input logic [2:0] div, input bit irq_on);
        drain();
        write_register(CFG_LSB_FIRST, CFG_DATA_W'(lsb));
        write_register(CFG_CLOCK_POL, CFG_DATA_W'(pol));
        write_register(CFG_CLOCK_PHA, CFG_DATA_W'(pha));
        write_register(CFG_DIV_SELECT, div);
        write_register(CFG_IRQ_ENABLE, CFG_DATA_W'(irq_on));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [2:0] random_div();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 3'($urandom_range(0, 2));
        else if (pick < 18)
            return 3'($urandom_range(3, 4));
        return 3'($urandom_range(5, 7));
    endfunction

    // Changes one or two registers, often while a transfer is still running.
    task automatic retune();
        logic [CFG_IDX_W-1:0] idx;
        drain();
        repeat ($urandom_range(1, 2)) begin
            idx = CFG_IDX_W'($urandom_range(CFG_LSB_FIRST, CFG_IRQ_ENABLE));
            if (idx == CFG_DIV_SELECT)
                write_register(idx, random_div());
            else
                write_register(idx, CFG_DATA_W'($urandom_range(0, 1)));
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req make_req(logic [1:0] kind, logic [7:0] wdata, logic miso_v);
        t_req r;
        r.req_type   = kind;
        r.write_data = wdata;
        r.miso       = miso_v;
        return r;
    endfunction

    // Mostly well-formed exchanges: a write, enough ticks to finish the byte,
    // then usually a read. Some noise and stray writes/reads mixed in.
    function automatic t_req next_stim();
        t_req r;
        int   eff;
        r = make_req(REQ_TICK, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            r.req_type = 2'($urandom_range(0, 3));
        end else if (ticks_left > 0) begin
            ticks_left--;
            case ($urandom_range(0, 19))
                0:       r.req_type = REQ_WRITE;
                1:       r.req_type = REQ_READ;
                2:       r.req_type = REQ_UNUSED;
                default: r.req_type = REQ_TICK;
            endcase
        end else if (read_owed && $urandom_range(0, 3) != 0) begin
            r.req_type = REQ_READ;
            read_owed  = 1'b0;
        end else begin
            r.req_type = REQ_WRITE;
            eff = int'((cur_div > DIV_SELECT_MAX) ? DIV_SELECT_MAX : cur_div);
            // Landing one short sometimes puts the next write on the last edge.
            ticks_left = ((2 * DATA_BITS) << eff) - 1 + int'($urandom_range(0, 3));
            read_owed  = ($urandom_range(0, 4) != 0);
        end
        return r;
    endfunction

    initial begin
        int seg;
        int seg_len;
        int random_items;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        burst_left   = 0;
        ticks_left   = 0;
        read_owed    = 1'b0;
        cur_div      = DIV_SELECT_RESET;
        sb = new();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one fast exchange with a stray write, both byte extremes,
        // an unused request code and a read that clears the flags.
        apply_settings(1'b0, 1'b0, 1'b0, 3'd0, 1'b1);
        send_beat(make_req(REQ_READ, 8'h00, 1'b1));
        send_beat(make_req(REQ_WRITE, 8'hFF, 1'b1));
        send_beat(make_req(REQ_WRITE, 8'h00, 1'b0));
        for (int k = 0; k < 14; k++)
            send_beat(make_req((k == 5) ? REQ_UNUSED : REQ_TICK, 8'h5A, k[0]));
        send_beat(make_req(REQ_READ, 8'hFF, 1'b0));

        // Random segments; the first few pin the divider extremes and cut
        // the slow transfers short with a divider change mid byte.
        random_items = 0;
        seg = 0;
        while (random_items < 900) begin
            case (seg)
                0: begin
                    apply_settings(1'b1, 1'b1, 1'b1, 3'd6, 1'b1);
                    seg_len = 220;
                end
                1: begin
                    drain();
                    write_register(CFG_DIV_SELECT, 3'd0);
                    i_cfg_we <= 1'b0;
                    seg_len = 60;
                end
                2: begin
                    apply_settings(1'b0, 1'b0, 1'b0, 3'd7, 1'b0);
                    seg_len = 150;
                end
                3: begin
                    drain();
                    write_register(CFG_DIV_SELECT, 3'd1);
                    i_cfg_we <= 1'b0;
                    seg_len = 60;
                end
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        retune();
                    else
                        apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                                       random_div(), 1'($urandom));
                    seg_len = $urandom_range(20, 120);
                end
            endcase
            for (int n = 0; n < seg_len; n++) begin
                send_beat(next_stim());
                random_items++;
            end
            seg++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("spi_master_byte_engine regression: pass");
        else
            $display("spi_master_byte_engine regression: fail");
        $finish;
    end

endmodule
